// File: hw/rtl/lmdm_pkg.sv
// ----------------------------------------------------------------------------
// lmdm_pkg
// Shared types, bus codes and constants of the lamp matrix duty monitor.
// ----------------------------------------------------------------------------
package lmdm_pkg;

	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 8;
	localparam int STROBE_W     = 10;
	localparam int CNT_W        = 6;
	localparam int WIN_W        = 7;
	localparam int ROW_IDX_W    = 4;
	localparam int LAMPS_PER_ROW = 8;
	localparam int DEFAULT_ROWS = 10;

	localparam logic [ADDR_W-1:0]   ADDR_STROBE      = 4'd8;
	localparam logic [ADDR_W-1:0]   ADDR_AUX_STROBE  = 4'd9;
	localparam logic [ADDR_W-1:0]   ADDR_DRIVE       = 4'd10;
	localparam logic [STROBE_W-1:0] FRAME_END_STROBE = 10'd512;
	localparam logic [CNT_W-1:0]    CNT_MAX          = 6'd63;
	localparam logic [WIN_W-1:0]    WINDOW_RESET     = 7'd40;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef cnt_t [LAMPS_PER_ROW-1:0] row_cnt_t;

	// lowest set strobe bit, zero when no bit is set
	function automatic logic [ROW_IDX_W-1:0] lowest_set(input logic [STROBE_W-1:0] v);
		logic [ROW_IDX_W-1:0] p;
		p = '0;
		for (int i = STROBE_W - 1; i >= 0; i--) begin
			if (v[i]) p = ROW_IDX_W'(i);
		end
		return p;
	endfunction

endpackage

// File: hw/rtl/lmdm_if.sv
// ----------------------------------------------------------------------------
// lmdm interfaces
// Valid/ready channels: snooped bus writes, row count results, window config.
// ----------------------------------------------------------------------------
interface lmdm_bus_if;
	import lmdm_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] bus_address;
	logic [DATA_W-1:0] bus_data_byte;
	modport source (output valid, output bus_address, output bus_data_byte, input ready);
	modport sink   (input valid, input bus_address, input bus_data_byte, output ready);
endinterface

interface lmdm_row_if;
	import lmdm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ROW_IDX_W-1:0] row_index;
	logic [CNT_W-1:0]     count_bit7;
	logic [CNT_W-1:0]     count_bit6;
	logic [CNT_W-1:0]     count_bit5;
	logic [CNT_W-1:0]     count_bit4;
	logic [CNT_W-1:0]     count_bit3;
	logic [CNT_W-1:0]     count_bit2;
	logic [CNT_W-1:0]     count_bit1;
	logic [CNT_W-1:0]     count_bit0;
	logic                 last_row;
	modport source (output valid, output row_index, output count_bit7, output count_bit6,
		output count_bit5, output count_bit4, output count_bit3, output count_bit2,
		output count_bit1, output count_bit0, output last_row, input ready);
	modport sink   (input valid, input row_index, input count_bit7, input count_bit6,
		input count_bit5, input count_bit4, input count_bit3, input count_bit2,
		input count_bit1, input count_bit0, input last_row, output ready);
endinterface

interface lmdm_cfg_if;
	import lmdm_pkg::*;
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/lamp_matrix_duty_monitor_core.sv
// ----------------------------------------------------------------------------
// lamp_matrix_duty_monitor_core
// Lamp duty monitor for a snooped lamp-matrix bus.
//
// in_bus takes one snooped write per beat (bus_address, bus_data_byte); a
// beat is accepted in every cycle that in_bus.ready is high, the strobe,
// row and counter state being updated in the cycle of acceptance. A drive
// write under the frame-end strobe adds every lit lamp to its saturating
// counter. When the frame count reaches window_frames minus one, the
// counters are copied into a row buffer and cleared; out_rows then carries
// ROWS beats, row 0 first, the next cycle after the closing input beat, one
// row per cycle while out_rows.ready is high. A stall on out_rows holds the
// head row; in_bus keeps taking beats during streaming except beats that
// could close another window, which wait until the last row is taken. cfg
// writes window_frames (always ready). Reset clears strobe, rows, counters
// and frame count and sets window_frames to 40; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lamp_matrix_duty_monitor_core #(
	parameter int ROWS = lmdm_pkg::DEFAULT_ROWS
) (
	input logic        clk,
	input logic        arst_n,
	lmdm_bus_if.sink   in_bus,
	lmdm_cfg_if.sink   cfg,
	lmdm_row_if.source out_rows
);
	import lmdm_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic             in_ready, accept, emit, emit_free;
	row_cnt_t         snap [ROWS];

	assign cfg.ready    = 1'b1;
	assign in_bus.ready = in_ready;
	assign accept       = in_bus.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg.valid) begin
			window_q <= cfg.data;
		end
	end

	lmdm_tracker #(.ROWS(ROWS)) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.addr      (in_bus.bus_address),
		.data      (in_bus.bus_data_byte),
		.window    (window_q),
		.emit_free (emit_free),
		.ready     (in_ready),
		.emit      (emit),
		.snap      (snap)
	);

	lmdm_emitter #(.ROWS(ROWS)) u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.snap   (snap),
		.free   (emit_free),
		.out    (out_rows)
	);

	a_emit_into_free_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> emit_free)
		else $error("window emitted while row buffer busy");

	a_rows_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_rows.valid && out_rows.ready && !out_rows.last_row) |=> out_rows.valid)
		else $error("row stream ended before last row");

	a_restart_at_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(out_rows.valid && out_rows.ready && out_rows.last_row)
		|=> (!out_rows.valid || out_rows.row_index == '0))
		else $error("new window does not start at row 0");

	a_emit_shows_row0: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_rows.valid && out_rows.row_index == '0))
		else $error("emitted window not presented");

endmodule

// File: hw/rtl/lmdm_tracker.sv
// ----------------------------------------------------------------------------
// lmdm_tracker
// Strobe and row registers, lamp counters and frame count; raises a window
// emit with a snapshot of the counters on the beat that closes a window.
// ----------------------------------------------------------------------------
module lmdm_tracker #(
	parameter int ROWS = lmdm_pkg::DEFAULT_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [lmdm_pkg::ADDR_W-1:0]   addr,
	input  logic [lmdm_pkg::DATA_W-1:0]   data,
	input  logic [lmdm_pkg::WIN_W-1:0]    window,
	input  logic                          emit_free,
	output logic                          ready,
	output logic                          emit,
	output lmdm_pkg::row_cnt_t            snap [ROWS]
);
	import lmdm_pkg::*;

	logic [STROBE_W-1:0]  strobe_q, strobe_d;
	logic [DATA_W-1:0]    row_q [ROWS];
	logic [DATA_W-1:0]    row_d [ROWS];
	row_cnt_t             cnt_q [ROWS];
	logic [CNT_W-1:0]     frame_q, frame_d, frame_inc;
	logic [WIN_W-1:0]     target;
	logic [ROW_IDX_W-1:0] pos;
	logic                 wr, drive_wr, frame_end, hit;

	assign wr        = accept && (data != '0);
	assign drive_wr  = wr && (addr == ADDR_DRIVE);
	assign pos       = lowest_set(strobe_q);
	assign frame_end = drive_wr && (strobe_q == FRAME_END_STROBE);
	assign target    = window - WIN_W'(1);
	assign frame_inc = frame_q + CNT_W'(1);
	assign frame_d   = frame_end ? frame_inc : frame_q;
	assign hit       = ({1'b0, frame_d} == target);
	assign emit      = accept && hit;

	// a window may close on this beat: hold off while rows are still streaming
	assign ready = emit_free || !(({1'b0, frame_q} == target) || ({1'b0, frame_inc} == target));

	always_comb begin
		strobe_d = strobe_q;
		if (wr && addr == ADDR_STROBE) begin
			strobe_d = {2'b00, data};
		end else if (wr && addr == ADDR_AUX_STROBE) begin
			strobe_d = {data[1:0], strobe_q[7:0]};
		end
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			row_d[r] = row_q[r];
			if (drive_wr && pos == ROW_IDX_W'(r)) begin
				row_d[r] = (strobe_q == '0) ? '0 : data;
			end
			for (int b = 0; b < LAMPS_PER_ROW; b++) begin
				snap[r][b] = cnt_q[r][b];
				if (frame_end && row_d[r][b] && cnt_q[r][b] != CNT_MAX) begin
					snap[r][b] = cnt_q[r][b] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= '0;
			frame_q  <= '0;
			for (int r = 0; r < ROWS; r++) begin
				row_q[r] <= '0;
				cnt_q[r] <= '0;
			end
		end else if (accept) begin
			strobe_q <= strobe_d;
			frame_q  <= hit ? '0 : frame_d;
			for (int r = 0; r < ROWS; r++) begin
				row_q[r] <= row_d[r];
				cnt_q[r] <= hit ? '0 : snap[r];
			end
		end
	end

endmodule

// File: hw/rtl/lmdm_emitter.sv
// ----------------------------------------------------------------------------
// lmdm_emitter
// Row buffer that takes a counter snapshot and streams it one row per beat.
// ----------------------------------------------------------------------------
module lmdm_emitter #(
	parameter int ROWS = lmdm_pkg::DEFAULT_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  lmdm_pkg::row_cnt_t snap [ROWS],
	output logic               free,
	lmdm_row_if.source         out
);
	import lmdm_pkg::*;

	row_cnt_t             buf_q [ROWS];
	logic                 valid_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic                 last, take;

	assign last = (row_q == ROW_IDX_W'(ROWS - 1));
	assign take = valid_q && out.ready;
	assign free = !valid_q || (take && last);

	assign out.valid      = valid_q;
	assign out.row_index  = row_q;
	assign out.last_row   = last;
	assign out.count_bit7 = buf_q[0][7];
	assign out.count_bit6 = buf_q[0][6];
	assign out.count_bit5 = buf_q[0][5];
	assign out.count_bit4 = buf_q[0][4];
	assign out.count_bit3 = buf_q[0][3];
	assign out.count_bit2 = buf_q[0][2];
	assign out.count_bit1 = buf_q[0][1];
	assign out.count_bit0 = buf_q[0][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			row_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			row_q   <= '0;
		end else if (take) begin
			valid_q <= !last;
			row_q   <= row_q + ROW_IDX_W'(1);
		end
	end

	// shift toward the head row
	always_ff @(posedge clk) begin
		if (load) begin
			for (int r = 0; r < ROWS; r++) buf_q[r] <= snap[r];
		end else if (take) begin
			for (int r = 0; r < ROWS - 1; r++) buf_q[r] <= buf_q[r + 1];
		end
	end

endmodule
